// File: rtl/read_watermark_table_core_assert.svh
// ---------------------------------------------------------------------------
// Read watermark table assertion macros
// Concurrent assertion helpers shared by the read watermark table RTL.
// ---------------------------------------------------------------------------
`ifndef READ_WATERMARK_TABLE_CORE_ASSERT_SVH
`define READ_WATERMARK_TABLE_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is asserted.
`define RWT_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("read watermark table: assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define RWT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("read watermark table: assertion failed");
`else
`define RWT_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define RWT_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// File: rtl/rwt_pkg.sv
// ---------------------------------------------------------------------------
// Read watermark table package
// Shared widths, request codes and sequencer states.
// ---------------------------------------------------------------------------
package rwt_pkg;

    // Default table size.
    localparam int SLOTS_DEFAULT = 64;

    // Field widths.
    localparam int FUNC_W    = 2;
    localparam int CHANNEL_W = 8;
    localparam int PREFIX_W  = 48;
    localparam int KEY_W     = 1 + CHANNEL_W + PREFIX_W;
    localparam int SEQ_W     = 32;
    localparam int SLOT_W    = 6;

    // One table entry: valid bit, key and watermark.
    localparam int ENTRY_W = 1 + KEY_W + SEQ_W;

    // Highest sequence number, start value of the oldest search.
    localparam logic [SEQ_W-1:0] SEQ_TOP = 32'hFFFF_FFFF;

    // Request codes.
    typedef enum logic [FUNC_W-1:0] {
        FUNC_MARK  = 2'd0,
        FUNC_CHECK = 2'd1,
        FUNC_CLEAR = 2'd2,
        FUNC_NONE  = 2'd3
    } func_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_SCAN,
        ST_CLEAR,
        ST_FINISH
    } state_t;

endpackage

// File: rtl/rwt_ram.sv
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module rwt_ram #(
    parameter int WIDTH = rwt_pkg::ENTRY_W,
    parameter int DEPTH = rwt_pkg::SLOTS_DEFAULT
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/read_watermark_table_core.sv
// ---------------------------------------------------------------------------
// Read watermark table core
// Per-conversation read watermarks with mark-read, check and clear requests.
// ---------------------------------------------------------------------------
// The table lives in one RAM of SLOTS entries (valid bit, key, watermark)
// with one write port and one registered read port, and one request is
// handled at a time. Mark-read and check walk the RAM one entry per cycle,
// overlapping each read with the compare of the previous entry, and stop at
// the first matching key. Clear writes every entry invalid; an unused request
// code goes straight to the result. After reset the same sweep writes every
// entry, and s_ready rises when it ends. A finished result waits in an output
// register; the next request is taken once the previous result is loaded.
// ---------------------------------------------------------------------------
module read_watermark_table_core #(
    parameter int SLOTS = rwt_pkg::SLOTS_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,

    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [rwt_pkg::FUNC_W-1:0]     s_func,
    input  logic                           s_conv_type,
    input  logic [rwt_pkg::CHANNEL_W-1:0]  s_conv_channel,
    input  logic [rwt_pkg::PREFIX_W-1:0]   s_conv_peer_prefix,
    input  logic [rwt_pkg::SEQ_W-1:0]      s_msg_sequence,
    input  logic                           s_is_incoming,

    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_status,
    output logic                           m_unread,
    output logic [rwt_pkg::SEQ_W-1:0]      m_watermark,
    output logic [rwt_pkg::SLOT_W-1:0]     m_written_slot
);

`include "read_watermark_table_core_assert.svh"

    localparam int IDXW  = $clog2(SLOTS);
    localparam int CNTW  = IDXW + 1;
    localparam logic [CNTW-1:0] LIMIT = CNTW'(SLOTS);
    localparam int KEY_W = rwt_pkg::KEY_W;
    localparam int SEQ_W = rwt_pkg::SEQ_W;

    // Sequencer and scan state.
    rwt_pkg::state_t state_reg, state_next;
    logic [CNTW-1:0]   idx_reg, idx_next;
    logic              pend_reg, pend_next;
    logic [IDXW-1:0]   pend_idx_reg, pend_idx_next;
    logic              found_reg, found_next;
    logic [IDXW-1:0]   match_idx_reg, match_idx_next;
    logic [SEQ_W-1:0]  match_wm_reg, match_wm_next;
    logic              free_found_reg, free_found_next;
    logic [IDXW-1:0]   free_idx_reg, free_idx_next;
    logic [SEQ_W-1:0]  oldest_reg, oldest_next;
    logic [IDXW-1:0]   oldest_idx_reg, oldest_idx_next;

    // Captured request.
    rwt_pkg::func_t    func_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [SEQ_W-1:0]  seq_reg;
    logic              incoming_reg;

    // Result register.
    logic                      m_valid_reg, m_valid_next;
    logic                      status_reg, status_next;
    logic                      unread_reg, unread_next;
    logic [SEQ_W-1:0]          wm_reg, wm_next;
    logic [rwt_pkg::SLOT_W-1:0] slot_reg, slot_next;

    // RAM ports.
    logic                         ram_we;
    logic [IDXW-1:0]              ram_waddr;
    logic [rwt_pkg::ENTRY_W-1:0]  ram_wdata;
    logic [IDXW-1:0]              ram_raddr;
    logic [rwt_pkg::ENTRY_W-1:0]  ram_rdata;

    // Decoded read entry.
    logic              rd_valid;
    logic [KEY_W-1:0]  rd_key;
    logic [SEQ_W-1:0]  rd_wm;

    // Shared less-than unit.
    logic [SEQ_W-1:0]  cmp_a, cmp_b;
    logic              cmp_lt;

    logic              accept;
    logic              scan_state;
    logic              idx_below;
    logic              hit;
    logic              scan_end;
    logic              fire;
    logic [SEQ_W-1:0]  current;
    logic [IDXW-1:0]   target;
    logic [IDXW+rwt_pkg::SLOT_W-1:0] target_ext;

    rwt_ram #(
        .WIDTH (rwt_pkg::ENTRY_W),
        .DEPTH (SLOTS)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_valid = ram_rdata[rwt_pkg::ENTRY_W-1];
    assign rd_key   = ram_rdata[SEQ_W +: KEY_W];
    assign rd_wm    = ram_rdata[SEQ_W-1:0];

    assign accept     = s_valid && s_ready;
    assign scan_state = (state_reg == rwt_pkg::ST_SCAN);
    assign idx_below  = (idx_reg < LIMIT);
    assign hit        = pend_reg && rd_valid && (rd_key == key_reg);
    assign scan_end   = hit || (!pend_reg && !idx_below);
    assign fire       = (state_reg == rwt_pkg::ST_FINISH) && (!m_valid_reg || m_ready);
    assign current    = found_reg ? match_wm_reg : '0;

    // One comparator: watermark against oldest while scanning,
    // current watermark against the request sequence at the end.
    always_comb begin
        if (scan_state) begin
            cmp_a = rd_wm;
            cmp_b = oldest_reg;
        end else begin
            cmp_a = current;
            cmp_b = seq_reg;
        end
    end
    assign cmp_lt = (cmp_a < cmp_b);

    // Slot for an accepted mark-read: match, else free, else oldest.
    always_comb begin
        if (found_reg) begin
            target = match_idx_reg;
        end else if (free_found_reg) begin
            target = free_idx_reg;
        end else begin
            target = oldest_idx_reg;
        end
    end
    assign target_ext = {{rwt_pkg::SLOT_W{1'b0}}, target};

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            rwt_pkg::ST_INIT: begin
                if (!idx_below) begin
                    state_next = rwt_pkg::ST_IDLE;
                end
            end
            rwt_pkg::ST_IDLE: begin
                if (accept) begin
                    unique case (rwt_pkg::func_t'(s_func))
                        rwt_pkg::FUNC_MARK, rwt_pkg::FUNC_CHECK:
                            state_next = rwt_pkg::ST_SCAN;
                        rwt_pkg::FUNC_CLEAR:
                            state_next = rwt_pkg::ST_CLEAR;
                        default:
                            state_next = rwt_pkg::ST_FINISH;
                    endcase
                end
            end
            rwt_pkg::ST_SCAN: begin
                if (scan_end) begin
                    state_next = rwt_pkg::ST_FINISH;
                end
            end
            rwt_pkg::ST_CLEAR: begin
                if (!idx_below) begin
                    state_next = rwt_pkg::ST_FINISH;
                end
            end
            rwt_pkg::ST_FINISH: begin
                if (fire) begin
                    state_next = rwt_pkg::ST_IDLE;
                end
            end
            default: state_next = rwt_pkg::ST_IDLE;
        endcase
    end

    // Outputs of the sequencer: RAM control and handshake.
    always_comb begin
        s_ready   = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = idx_reg[IDXW-1:0];
        ram_wdata = '0;
        ram_raddr = idx_below ? idx_reg[IDXW-1:0] : '0;
        unique case (state_reg)
            rwt_pkg::ST_INIT, rwt_pkg::ST_CLEAR: begin
                ram_we = idx_below;
            end
            rwt_pkg::ST_IDLE: begin
                s_ready = 1'b1;
            end
            rwt_pkg::ST_FINISH: begin
                ram_waddr = target;
                ram_wdata = {1'b1, key_reg, seq_reg};
                ram_we    = fire && (func_reg == rwt_pkg::FUNC_MARK) && cmp_lt;
            end
            default: begin
            end
        endcase
    end

    // Scan bookkeeping.
    always_comb begin
        idx_next        = idx_reg;
        pend_next       = 1'b0;
        pend_idx_next   = idx_reg[IDXW-1:0];
        found_next      = found_reg;
        match_idx_next  = match_idx_reg;
        match_wm_next   = match_wm_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        oldest_next     = oldest_reg;
        oldest_idx_next = oldest_idx_reg;
        unique case (state_reg)
            rwt_pkg::ST_INIT, rwt_pkg::ST_CLEAR: begin
                if (idx_below) begin
                    idx_next = idx_reg + CNTW'(1);
                end
            end
            rwt_pkg::ST_IDLE: begin
                idx_next        = '0;
                found_next      = 1'b0;
                free_found_next = 1'b0;
                oldest_next     = rwt_pkg::SEQ_TOP;
                oldest_idx_next = '0;
            end
            rwt_pkg::ST_SCAN: begin
                // Issue the next read while the previous entry is compared.
                if (idx_below && !hit) begin
                    idx_next  = idx_reg + CNTW'(1);
                    pend_next = 1'b1;
                end
                if (pend_reg) begin
                    if (!rd_valid) begin
                        if (!free_found_reg) begin
                            free_found_next = 1'b1;
                            free_idx_next   = pend_idx_reg;
                        end
                    end else if (hit) begin
                        found_next     = 1'b1;
                        match_idx_next = pend_idx_reg;
                        match_wm_next  = rd_wm;
                    end else if (cmp_lt) begin
                        oldest_next     = rd_wm;
                        oldest_idx_next = pend_idx_reg;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Result formation.
    always_comb begin
        status_next  = status_reg;
        unread_next  = unread_reg;
        wm_next      = wm_reg;
        slot_next    = slot_reg;
        m_valid_next = m_valid_reg && !m_ready;
        if (fire) begin
            m_valid_next = 1'b1;
            status_next  = 1'b0;
            unread_next  = 1'b0;
            wm_next      = '0;
            slot_next    = '0;
            case (func_reg)
                rwt_pkg::FUNC_MARK: begin
                    wm_next     = current;
                    status_next = !cmp_lt;
                    if (cmp_lt) begin
                        slot_next = target_ext[rwt_pkg::SLOT_W-1:0];
                    end
                end
                rwt_pkg::FUNC_CHECK: begin
                    wm_next     = current;
                    unread_next = incoming_reg && cmp_lt;
                end
                default: begin
                end
            endcase
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= rwt_pkg::ST_INIT;
            idx_reg     <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload and search registers.
    always_ff @(posedge aclk) begin
        pend_idx_reg   <= pend_idx_next;
        found_reg      <= found_next;
        match_idx_reg  <= match_idx_next;
        match_wm_reg   <= match_wm_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        oldest_reg     <= oldest_next;
        oldest_idx_reg <= oldest_idx_next;
        status_reg     <= status_next;
        unread_reg     <= unread_next;
        wm_reg         <= wm_next;
        slot_reg       <= slot_next;
        if (accept) begin
            func_reg     <= rwt_pkg::func_t'(s_func);
            key_reg      <= {s_conv_type, s_conv_channel, s_conv_peer_prefix};
            seq_reg      <= s_msg_sequence;
            incoming_reg <= s_is_incoming;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = status_reg;
    assign m_unread       = unread_reg;
    assign m_watermark    = wm_reg;
    assign m_written_slot = slot_reg;

    // Checks on the sequencer and result.
    `RWT_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, accept, !s_ready)
    `RWT_ASSERT_IMPL(a_scan_in_range, aclk, aresetn, scan_state, idx_reg <= LIMIT)
    `RWT_ASSERT_IMPL(a_write_states, aclk, aresetn, ram_we, !s_ready && !scan_state)
    `RWT_ASSERT_IMPL(a_reject_no_slot, aclk, aresetn, m_valid && m_status, m_written_slot == '0)

endmodule
